>>> sv/pm1_pkg.sv
// ----------------------------------------------------------------------------
// pm1_pkg
// Shared widths and types for the p-1 factoring block.
// ----------------------------------------------------------------------------
`default_nettype none

package pm1_pkg;

    localparam int MOD_BITS   = 32;
    localparam int BOUND_BITS = 16;
    localparam int SHIFT_BITS = $clog2(MOD_BITS + 1);
    localparam int MCNT_BITS  = $clog2(MOD_BITS);
    localparam int BPOS_BITS  = $clog2(BOUND_BITS);

    typedef logic [MOD_BITS-1:0]   mod_word_t;
    typedef logic [BOUND_BITS-1:0] bound_word_t;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_JSTART = 8'b0000_0010,
        S_BIT    = 8'b0000_0100,
        S_SQ     = 8'b0000_1000,
        S_MULGO  = 8'b0001_0000,
        S_MUL    = 8'b0010_0000,
        S_GCD    = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } seq_state_t;

endpackage : pm1_pkg

`default_nettype wire

>>> sv/pm1_modmul.sv
// ----------------------------------------------------------------------------
// pm1_modmul
// Bit-serial modular multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pm1_modmul
    import pm1_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      go,
    input  wire mod_word_t x,
    input  wire mod_word_t y,
    input  wire mod_word_t m,
    output logic           fin,
    output mod_word_t      prod
);

    logic                 run_reg, run_next;
    logic [MCNT_BITS-1:0] cnt_reg, cnt_next;
    mod_word_t            acc_reg, acc_next;
    mod_word_t            x_reg, x_next;
    mod_word_t            y_reg, y_next;
    mod_word_t            m_reg, m_next;
    logic [MOD_BITS:0]    dbl;
    mod_word_t            dbl_red;
    logic [MOD_BITS:0]    sum;
    mod_word_t            sum_red;

    always_comb
    begin
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, m_reg}) ? mod_word_t'(dbl - {1'b0, m_reg}) : dbl[MOD_BITS-1:0];
        sum     = {1'b0, dbl_red} + {1'b0, x_reg};
        if (!y_reg[MOD_BITS-1])
        begin
            sum_red = dbl_red;
        end
        else if (sum >= {1'b0, m_reg})
        begin
            sum_red = mod_word_t'(sum - {1'b0, m_reg});
        end
        else
        begin
            sum_red = sum[MOD_BITS-1:0];
        end
    end

    always_comb
    begin
        run_next = run_reg;
        cnt_next = cnt_reg;
        acc_next = acc_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        m_next   = m_reg;
        fin      = 1'b0;
        if (go)
        begin
            run_next = 1'b1;
            cnt_next = MCNT_BITS'(MOD_BITS - 1);
            acc_next = '0;
            x_next   = x;
            y_next   = y;
            m_next   = m;
        end
        else if (run_reg)
        begin
            acc_next = sum_red;
            y_next   = {y_reg[MOD_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                run_next = 1'b0;
                fin      = 1'b1;
            end
        end
    end

    assign prod = sum_red;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        m_reg   <= m_next;
    end

endmodule : pm1_modmul

`default_nettype wire

>>> sv/pm1_gcd.sv
// ----------------------------------------------------------------------------
// pm1_gcd
// Binary greatest common divisor, one shift or subtraction per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pm1_gcd
    import pm1_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      go,
    input  wire mod_word_t a,
    input  wire mod_word_t b,
    output logic           fin,
    output mod_word_t      g
);

    logic                  run_reg, run_next;
    mod_word_t             u_reg, u_next;
    mod_word_t             v_reg, v_next;
    logic [SHIFT_BITS-1:0] k_reg, k_next;

    always_comb
    begin
        run_next = run_reg;
        u_next   = u_reg;
        v_next   = v_reg;
        k_next   = k_reg;
        fin      = 1'b0;
        if (go)
        begin
            run_next = 1'b1;
            u_next   = a;
            v_next   = b;
            k_next   = '0;
        end
        else if (run_reg)
        begin
            if (u_reg == '0)
            begin
                run_next = 1'b0;
                fin      = 1'b1;
            end
            else if (!u_reg[0] && !v_reg[0])
            begin
                u_next = u_reg >> 1;
                v_next = v_reg >> 1;
                k_next = k_reg + 1'b1;
            end
            else if (!u_reg[0])
            begin
                u_next = u_reg >> 1;
            end
            else if (!v_reg[0])
            begin
                v_next = v_reg >> 1;
            end
            else if (u_reg >= v_reg)
            begin
                u_next = u_reg - v_reg;
            end
            else
            begin
                v_next = v_reg - u_reg;
            end
        end
    end

    assign g = v_reg << k_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            k_reg   <= '0;
        end
        else
        begin
            run_reg <= run_next;
            k_reg   <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg <= u_next;
        v_reg <= v_next;
    end

endmodule : pm1_gcd

`default_nettype wire

>>> sv/pollard_p_minus_1_factor.sv
// ----------------------------------------------------------------------------
// pollard_p_minus_1_factor
// Pollard p-1 factoring with a shared serial multiplier and a binary gcd.
//
// Channel   Signals                      Direction  Handshake
// request   start, modulus, stage_limit  in         start & !busy
// result    done, found, factor,         out        done, one cycle
//           stage_hit
//
// Stage j costs about 2*log2(j) products plus a scan of the bits of j and a
// binary gcd; stages run until a hit or the bound. A zero modulus or a bound
// below two gives its result in the cycle after acceptance.
// Reset is asynchronous and returns the block to idle. Busy stays high from
// acceptance through the result cycle; the receiver cannot stall the result.
// ----------------------------------------------------------------------------
`default_nettype none

module pollard_p_minus_1_factor
    import pm1_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire mod_word_t   modulus,
    input  wire bound_word_t stage_limit,
    output logic             done,
    output logic             found,
    output mod_word_t        factor,
    output bound_word_t      stage_hit
);

    seq_state_t           state_reg, state_next;
    mod_word_t            n_reg, n_next;
    bound_word_t          lim_reg, lim_next;
    bound_word_t          j_reg, j_next;
    mod_word_t            a_reg, a_next;
    mod_word_t            z_reg, z_next;
    logic [BPOS_BITS-1:0] bpos_reg, bpos_next;
    logic                 seen_reg, seen_next;
    logic                 found_reg, found_next;
    mod_word_t            factor_reg, factor_next;
    bound_word_t          hit_reg, hit_next;

    logic      mul_go;
    mod_word_t mul_x;
    mod_word_t mul_y;
    logic      mul_fin;
    mod_word_t mul_p;
    logic      gcd_go;
    mod_word_t gcd_a;
    logic      gcd_fin;
    mod_word_t gcd_g;

    pm1_modmul u_mul (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (mul_go),
        .x    (mul_x),
        .y    (mul_y),
        .m    (n_reg),
        .fin  (mul_fin),
        .prod (mul_p)
    );

    pm1_gcd u_gcd (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (gcd_go),
        .a    (gcd_a),
        .b    (n_reg),
        .fin  (gcd_fin),
        .g    (gcd_g)
    );

    always_comb
    begin
        state_next  = state_reg;
        n_next      = n_reg;
        lim_next    = lim_reg;
        j_next      = j_reg;
        a_next      = a_reg;
        z_next      = z_reg;
        bpos_next   = bpos_reg;
        seen_next   = seen_reg;
        found_next  = found_reg;
        factor_next = factor_reg;
        hit_next    = hit_reg;
        mul_go      = 1'b0;
        mul_x       = z_reg;
        mul_y       = z_reg;
        gcd_go      = 1'b0;
        gcd_a       = (z_reg == '0) ? n_reg - 1'b1 : z_reg - 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    n_next      = modulus;
                    lim_next    = stage_limit;
                    j_next      = BOUND_BITS'(2);
                    a_next      = (modulus > MOD_BITS'(2)) ? MOD_BITS'(2) : '0;
                    found_next  = 1'b0;
                    factor_next = '0;
                    hit_next    = '0;
                    if (modulus == '0 || stage_limit < BOUND_BITS'(2))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_JSTART;
                    end
                end
            end
            S_JSTART:
            begin
                z_next     = (n_reg == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
                bpos_next  = BPOS_BITS'(BOUND_BITS - 1);
                seen_next  = 1'b0;
                state_next = S_BIT;
            end
            S_BIT:
            begin
                if (seen_reg || j_reg[bpos_reg])
                begin
                    seen_next  = 1'b1;
                    mul_go     = 1'b1;
                    state_next = S_SQ;
                end
                else
                begin
                    bpos_next = bpos_reg - 1'b1;
                end
            end
            S_SQ:
            begin
                if (mul_fin)
                begin
                    z_next = mul_p;
                    if (j_reg[bpos_reg])
                    begin
                        state_next = S_MULGO;
                    end
                    else if (bpos_reg == '0)
                    begin
                        state_next = S_GCD;
                    end
                    else
                    begin
                        bpos_next  = bpos_reg - 1'b1;
                        state_next = S_BIT;
                    end
                end
            end
            S_MULGO:
            begin
                mul_go     = 1'b1;
                mul_y      = a_reg;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (mul_fin)
                begin
                    z_next = mul_p;
                    if (bpos_reg == '0)
                    begin
                        state_next = S_GCD;
                    end
                    else
                    begin
                        bpos_next  = bpos_reg - 1'b1;
                        state_next = S_BIT;
                    end
                end
            end
            S_GCD:
            begin
                if (!seen_reg)
                begin
                    if (gcd_fin)
                    begin
                        if (gcd_g > MOD_BITS'(1) && gcd_g < n_reg)
                        begin
                            found_next  = 1'b1;
                            factor_next = gcd_g;
                            hit_next    = j_reg;
                            state_next  = S_DONE;
                        end
                        else if (j_reg == lim_reg)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            j_next     = j_reg + 1'b1;
                            state_next = S_JSTART;
                        end
                    end
                end
                else
                begin
                    gcd_go    = 1'b1;
                    a_next    = z_reg;
                    seen_next = 1'b0;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = (state_reg == S_DONE);
    assign found     = found_reg;
    assign factor    = factor_reg;
    assign stage_hit = hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            seen_reg  <= 1'b0;
            bpos_reg  <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            seen_reg  <= seen_next;
            bpos_reg  <= bpos_next;
            j_reg     <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        lim_reg    <= lim_next;
        a_reg      <= a_next;
        z_reg      <= z_next;
        found_reg  <= found_next;
        factor_reg <= factor_next;
        hit_reg    <= hit_next;
    end

endmodule : pollard_p_minus_1_factor

`default_nettype wire

>>> verif/pm1_result_checker.sv
// ----------------------------------------------------------------------------
// pm1_result_checker
// Watches the request and result channels of the p-1 factoring block,
// predicts each result from the accepted request and compares field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module pm1_result_checker
    import pm1_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire mod_word_t   modulus,
    input  wire bound_word_t stage_limit,
    input  wire logic        done,
    input  wire logic        found,
    input  wire mod_word_t   factor,
    input  wire bound_word_t stage_hit,
    output int               fail_count,
    output int               pending_count
);

    typedef struct packed {
        logic        found;
        mod_word_t   factor;
        bound_word_t stage_hit;
    } factor_result_t;

    factor_result_t expected_factors[$];

    function automatic longint unsigned mod_product(longint unsigned x, longint unsigned y,
                                                    longint unsigned n);
        return (x * y) % n;
    endfunction

    function automatic longint unsigned mod_power(longint unsigned b, longint unsigned e,
                                                  longint unsigned n);
        longint unsigned z;
        z = 1 % n;
        for (int i = 63; i >= 0; i--)
        begin
            if ((e >> i) != 0)
            begin
                z = mod_product(z, z, n);
                if (e[i])
                    z = mod_product(z, b, n);
            end
        end
        return z;
    endfunction

    function automatic longint unsigned common_divisor(longint unsigned x, longint unsigned y);
        longint unsigned r;
        while (x != 0)
        begin
            r = y % x;
            y = x;
            x = r;
        end
        return y;
    endfunction

    function automatic factor_result_t search_factor(mod_word_t m, bound_word_t limit);
        factor_result_t res;
        longint unsigned n, a, d;
        res = '0;
        n = 64'(m);
        if (n == 0)
            return res;
        a = 2 % n;
        for (int unsigned j = 2; j <= limit; j++)
        begin
            a = mod_power(a, j, n);
            d = common_divisor((a == 0) ? n - 1 : a - 1, n);
            if (d > 1 && d < n)
            begin
                res.found     = 1'b1;
                res.factor    = mod_word_t'(d);
                res.stage_hit = bound_word_t'(j);
                return res;
            end
        end
        return res;
    endfunction

    assign pending_count = expected_factors.size();

    always @(posedge clk or negedge rst_n)
    begin
        factor_result_t want;
        if (!rst_n)
        begin
            fail_count <= 0;
            expected_factors.delete();
        end
        else
        begin
            if (done)
            begin
                if (expected_factors.size() == 0)
                begin
                    $error("unexpected result: found %0d factor %0d stage %0d",
                           found, factor, stage_hit);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_factors.pop_front();
                    if (found !== want.found || factor !== want.factor
                        || stage_hit !== want.stage_hit)
                        fail_count <= fail_count + 1;
                    if (found !== want.found)
                        $error("found: expected %0d, actual %0d", want.found, found);
                    if (factor !== want.factor)
                        $error("factor: expected %0d, actual %0d", want.factor, factor);
                    if (stage_hit !== want.stage_hit)
                        $error("stage_hit: expected %0d, actual %0d",
                               want.stage_hit, stage_hit);
                end
            end
            if (start && !busy)
                expected_factors = {expected_factors, search_factor(modulus, stage_limit)};
        end
    end

endmodule : pm1_result_checker

`default_nettype wire

>>> verif/tb_pollard_p_minus_1_factor.sv
// ----------------------------------------------------------------------------
// tb_pollard_p_minus_1_factor
// Drives directed and random factoring requests with random idle bursts into
// the p-1 factoring block; a separate checker predicts and compares results.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_pollard_p_minus_1_factor;
    import pm1_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    mod_word_t   modulus;
    bound_word_t stage_limit;
    logic        done;
    logic        found;
    mod_word_t   factor;
    bound_word_t stage_hit;
    int          fail_count;
    int          pending_count;

    pollard_p_minus_1_factor uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .modulus     (modulus),
        .stage_limit (stage_limit),
        .done        (done),
        .found       (found),
        .factor      (factor),
        .stage_hit   (stage_hit)
    );

    pm1_result_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .modulus       (modulus),
        .stage_limit   (stage_limit),
        .done          (done),
        .found         (found),
        .factor        (factor),
        .stage_hit     (stage_hit),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #60000000;
        $display("tb: failure");
        $finish;
    end

    // The request is held until the block accepts it; idle bursts follow only
    // when asked for, so back-to-back requests keep start high.
    task automatic send_request(mod_word_t m, bound_word_t limit, bit allow_idle);
        int gap;
        start       <= 1'b1;
        modulus     <= m;
        stage_limit <= limit;
        do
            @(posedge clk);
        while (busy);
        gap = (allow_idle && $urandom_range(0, 2) == 0) ? $urandom_range(1, 13) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin
        int kind;
        mod_word_t m;
        start       = 1'b0;
        modulus     = '0;
        stage_limit = '0;
        rst_n       = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(32'd0, 16'hFFFF, 1'b1);
        send_request(32'd0, 16'd0, 1'b0);
        send_request(32'd1, 16'd6, 1'b1);
        send_request(32'd2, 16'd6, 1'b0);
        send_request(32'd3, 16'd10, 1'b1);
        send_request(32'd4, 16'd10, 1'b0);
        send_request(32'hFFFFFFFF, 16'd0, 1'b1);
        send_request(32'hFFFFFFFF, 16'd1, 1'b0);
        send_request(32'hFFFFFFFF, 16'hFFFF, 1'b1);
        send_request(32'd65521, 16'd20, 1'b0);
        send_request(32'hFFFFFFFB, 16'd16, 1'b1);
        send_request(32'd15, 16'd2, 1'b0);
        send_request(32'd1517, 16'd12, 1'b1);
        send_request(32'd2047, 16'd12, 1'b0);
        send_request(32'd3 * 32'd1431655765, 16'h8000, 1'b1);
        send_request(32'h80000000, 16'd8, 1'b0);

        for (int i = 0; i < 100; i++)
        begin
            kind = $urandom_range(0, 3);
            if (kind == 0)
            begin
                // A multiple of three above three hits at the first stage,
                // so the bound can take any value without a long run.
                m = 32'd3 * mod_word_t'($urandom_range(2, 32'd1431655765));
                send_request(m, bound_word_t'($urandom), i < 80);
            end
            else if (kind == 1)
            begin
                m = mod_word_t'($urandom_range(5, 300)) * mod_word_t'($urandom_range(5, 3000));
                send_request(m, bound_word_t'($urandom_range(0, 24)), i < 80);
            end
            else
                send_request(mod_word_t'($urandom), bound_word_t'($urandom_range(0, 24)),
                             i < 80);
        end
        start <= 1'b0;

        do
            @(posedge clk);
        while (pending_count != 0 || busy);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule : tb_pollard_p_minus_1_factor

`default_nettype wire

>>> files.f
sv/pm1_pkg.sv
sv/pm1_modmul.sv
sv/pm1_gcd.sv
sv/pollard_p_minus_1_factor.sv
verif/pm1_result_checker.sv
verif/tb_pollard_p_minus_1_factor.sv
